>>> design/dwpi_pkg.sv
// Package for the two-wheel PI speed controller.
// Holds request and register codes, register reset values and shared structs.
// No dependencies.
package dwpi_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int GAIN_WIDTH     = 16;
    localparam int TOL_WIDTH      = 15;
    localparam int DECAY_BITS     = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam logic [GAIN_WIDTH-1:0] P_GAIN_RST  = 16'd4096;
    localparam logic [GAIN_WIDTH-1:0] I_GAIN_RST  = 16'd410;
    localparam logic [DECAY_BITS-1:0] I_DECAY_RST = 16'd62259;
    localparam logic [TOL_WIDTH-1:0]  TOL_RST     = 15'd205;

    typedef enum logic [1:0] {
        REQ_SET  = 2'd0,
        REQ_TICK = 2'd1,
        REQ_STOP = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_P_GAIN  = 2'd0,
        CFG_I_GAIN  = 2'd1,
        CFG_I_DECAY = 2'd2,
        CFG_TOL     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] p_gain;
        logic [GAIN_WIDTH-1:0] i_gain;
        logic [DECAY_BITS-1:0] i_decay;
        logic [TOL_WIDTH-1:0]  change_tolerance;
    } cfg_t;

    typedef struct packed {
        logic set;
        logic tick;
        logic stop;
    } op_t;

endpackage

>>> design/dwpi_cfg.sv
// Configuration register bank for the PI speed controller.
// Depends on dwpi_pkg.
module dwpi_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dwpi_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [dwpi_pkg::GAIN_WIDTH-1:0]    cfg_wr_data,
    output dwpi_pkg::cfg_t                     cfg
);

    dwpi_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (dwpi_pkg::cfg_idx_t'(cfg_index))
                dwpi_pkg::CFG_P_GAIN:  cfg_next.p_gain  = cfg_wr_data;
                dwpi_pkg::CFG_I_GAIN:  cfg_next.i_gain  = cfg_wr_data;
                dwpi_pkg::CFG_I_DECAY: cfg_next.i_decay = cfg_wr_data;
                dwpi_pkg::CFG_TOL:
                    cfg_next.change_tolerance = cfg_wr_data[dwpi_pkg::TOL_WIDTH-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.p_gain           <= dwpi_pkg::P_GAIN_RST;
            cfg_reg.i_gain           <= dwpi_pkg::I_GAIN_RST;
            cfg_reg.i_decay          <= dwpi_pkg::I_DECAY_RST;
            cfg_reg.change_tolerance <= dwpi_pkg::TOL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/dwpi_wheel.sv
// One wheel of the PI speed controller: target and integral state, drive
// and integrator update. Depends on dwpi_pkg.
module dwpi_wheel #(
    parameter int DATA_WIDTH = dwpi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = dwpi_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dwpi_pkg::op_t                op,
    input  dwpi_pkg::cfg_t               cfg,
    input  logic signed [DATA_WIDTH-1:0] target,
    input  logic signed [DATA_WIDTH-1:0] measured,
    output logic signed [DATA_WIDTH-1:0] drive
);

    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int PROD_W = ERR_W + dwpi_pkg::GAIN_WIDTH + 1;
    localparam int LEAK_W = DATA_WIDTH + dwpi_pkg::DECAY_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMP_W  = (ERR_W > dwpi_pkg::TOL_WIDTH) ? ERR_W : dwpi_pkg::TOL_WIDTH;

    logic signed [DATA_WIDTH-1:0] target_reg, target_next;
    logic signed [DATA_WIDTH-1:0] integ_reg, integ_next;

    logic signed [ERR_W-1:0]             diff;
    logic        [ERR_W-1:0]             abs_diff;
    logic                                clr;
    logic signed [DATA_WIDTH-1:0]        tgt_use;
    logic signed [DATA_WIDTH-1:0]        integ_use;
    logic signed [ERR_W-1:0]             err;
    logic        [dwpi_pkg::GAIN_WIDTH-1:0] gain;
    logic signed [PROD_W-1:0]            prod;
    logic signed [PROD_W-1:0]            scaled;
    logic signed [LEAK_W-1:0]            leak_prod;
    logic signed [LEAK_W-1:0]            leak;
    logic signed [SUM_W-1:0]             sum_drive;
    logic signed [SUM_W-1:0]             sum_tick;

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic ovf;
        ovf = (v[SUM_W-1:DATA_WIDTH-1] != {(SUM_W-DATA_WIDTH+1){v[SUM_W-1]}});
        if (ovf)
            return {v[SUM_W-1], {(DATA_WIDTH-1){~v[SUM_W-1]}}};
        return v[DATA_WIDTH-1:0];
    endfunction

    always_comb begin
        diff      = {target[DATA_WIDTH-1], target} - {target_reg[DATA_WIDTH-1], target_reg};
        abs_diff  = diff[ERR_W-1] ? (~diff + ERR_W'(1)) : diff;
        clr       = CMP_W'(abs_diff) > CMP_W'(cfg.change_tolerance);
        tgt_use   = op.set ? target : target_reg;
        integ_use = (op.set && clr) ? '0 : integ_reg;
        err       = {tgt_use[DATA_WIDTH-1], tgt_use} - {measured[DATA_WIDTH-1], measured};
        gain      = op.set ? cfg.p_gain : cfg.i_gain;
        prod      = PROD_W'(err) * PROD_W'($signed({1'b0, gain}));
        scaled    = prod >>> FRAC_BITS;
        leak_prod = LEAK_W'(integ_reg) * LEAK_W'($signed({1'b0, cfg.i_decay}));
        leak      = leak_prod >>> dwpi_pkg::DECAY_BITS;
        sum_drive = SUM_W'(scaled) + SUM_W'(integ_use);
        sum_tick  = SUM_W'(scaled) + SUM_W'(leak);
        drive     = sat(sum_drive);
    end

    always_comb begin
        target_next = target_reg;
        integ_next  = integ_reg;
        if (op.stop) begin
            target_next = '0;
            integ_next  = '0;
        end else if (op.set) begin
            target_next = target;
            integ_next  = integ_use;
        end else if (op.tick) begin
            integ_next  = sat(sum_tick);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            integ_reg  <= '0;
        end else begin
            target_reg <= target_next;
            integ_reg  <= integ_next;
        end
    end

endmodule

>>> design/dual_wheel_pi_speed_control_unit.sv
// Top level of the two-wheel PI speed controller: request register, two
// wheel units, config bank and result register. Depends on dwpi_pkg,
// dwpi_cfg and dwpi_wheel.
//
//   port group   dir  handshake            payload
//   s_*          in   s_valid / s_ready    req_type, targets, measured speeds
//   m_*          out  m_valid / m_ready    drive_left, drive_right, drive_enable
//   cfg_*        in   cfg_wr_en            cfg_index, cfg_wr_data
//
// One request per cycle while the result register is free or m_ready is high; a set or
// stop result passes from the request register to the result register. The wheel
// update (subtract, multiplies, add, saturate) sits between the request register
// and the state and result registers. Tick requests retire without waiting on m_ready.
// Reset clears targets, integrals and valids and loads register defaults.
module dual_wheel_pi_speed_control_unit #(
    parameter int DATA_WIDTH = dwpi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = dwpi_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic signed [DATA_WIDTH-1:0]       s_target_left,
    input  logic signed [DATA_WIDTH-1:0]       s_target_right,
    input  logic signed [DATA_WIDTH-1:0]       s_measured_left,
    input  logic signed [DATA_WIDTH-1:0]       s_measured_right,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_drive_left,
    output logic signed [DATA_WIDTH-1:0]       m_drive_right,
    output logic                               m_drive_enable,
    input  logic                               cfg_wr_en,
    input  logic [dwpi_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [dwpi_pkg::GAIN_WIDTH-1:0]    cfg_wr_data
);

    dwpi_pkg::cfg_t cfg;
    dwpi_pkg::op_t  op;

    logic                         in_valid_reg;
    logic [1:0]                   req_reg;
    logic signed [DATA_WIDTH-1:0] tl_reg, tr_reg, ml_reg, mr_reg;

    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] dl_reg, dr_reg;
    logic                         en_reg;

    logic signed [DATA_WIDTH-1:0] drive_l, drive_r;
    logic                         has_result;
    logic                         advance;

    dwpi_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    always_comb begin
        op = '0;
        has_result = 1'b0;
        case (dwpi_pkg::req_t'(req_reg))
            dwpi_pkg::REQ_SET: begin
                op.set = 1'b1;
                has_result = 1'b1;
            end
            dwpi_pkg::REQ_TICK: op.tick = 1'b1;
            dwpi_pkg::REQ_STOP: begin
                op.stop = 1'b1;
                has_result = 1'b1;
            end
            default: begin
                op = '0;
                has_result = 1'b0;
            end
        endcase
        advance = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
        if (!advance)
            op = '0;
    end

    assign s_ready = !in_valid_reg || advance;

    dwpi_wheel #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .cfg      (cfg),
        .target   (tl_reg),
        .measured (ml_reg),
        .drive    (drive_l)
    );

    dwpi_wheel #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .cfg      (cfg),
        .target   (tr_reg),
        .measured (mr_reg),
        .drive    (drive_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req_type;
            tl_reg  <= s_target_left;
            tr_reg  <= s_target_right;
            ml_reg  <= s_measured_left;
            mr_reg  <= s_measured_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            dl_reg <= op.set ? drive_l : '0;
            dr_reg <= op.set ? drive_r : '0;
            en_reg <= op.set;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_drive_left   = dl_reg;
    assign m_drive_right  = dr_reg;
    assign m_drive_enable = en_reg;

endmodule

>>> design/dwpi_checker.sv
// Port-level checks for the PI speed controller, bound to the top level.
// Depends on dwpi_pkg and dual_wheel_pi_speed_control_unit.
module dwpi_checker #(
    parameter int DATA_WIDTH = dwpi_pkg::DATA_WIDTH_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [DATA_WIDTH-1:0]       m_drive_left,
    input logic signed [DATA_WIDTH-1:0]       m_drive_right,
    input logic                               m_drive_enable
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_drive_left) && $stable(m_drive_right)
                                && $stable(m_drive_enable))
        else $error("result changed while stalled");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drive_enable |-> m_drive_left == '0 && m_drive_right == '0)
        else $error("stop result carries nonzero drive");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind dual_wheel_pi_speed_control_unit dwpi_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dwpi_checker (.*);

>>> tb/sv/dual_wheel_pi_speed_control_unit_checker.sv
// Scoreboard for the two-wheel PI speed controller: mirrors the config port,
// predicts drive commands per accepted set or stop request and compares them in order.
// Depends on dwpi_pkg.
module dual_wheel_pi_speed_control_unit_checker #(
    parameter int DATA_WIDTH = dwpi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = dwpi_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic signed [DATA_WIDTH-1:0]       s_target_left,
    input  logic signed [DATA_WIDTH-1:0]       s_target_right,
    input  logic signed [DATA_WIDTH-1:0]       s_measured_left,
    input  logic signed [DATA_WIDTH-1:0]       s_measured_right,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [DATA_WIDTH-1:0]       m_drive_left,
    input  logic signed [DATA_WIDTH-1:0]       m_drive_right,
    input  logic                               m_drive_enable,
    input  logic                               cfg_wr_en,
    input  logic [dwpi_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [dwpi_pkg::GAIN_WIDTH-1:0]    cfg_wr_data,
    output int                                 mismatch_count,
    output int                                 drives_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dwpi_pkg::*;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] left;
        logic signed [DATA_WIDTH-1:0] right;
        logic                         enable;
    } drive_cmd_t;

    logic signed [DATA_WIDTH-1:0] tgt_left;
    logic signed [DATA_WIDTH-1:0] tgt_right;
    logic signed [DATA_WIDTH-1:0] integ_left;
    logic signed [DATA_WIDTH-1:0] integ_right;
    int gain_p;
    int gain_i;
    int decay;
    int tolerance;
    int fail_total;
    drive_cmd_t drive_queue[$];

    function automatic longint clamp_speed(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - longint'(1);
        lo = -hi - longint'(1);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void retarget(inout logic signed [DATA_WIDTH-1:0] tgt,
                                     inout logic signed [DATA_WIDTH-1:0] integ,
                                     input logic signed [DATA_WIDTH-1:0] next);
        longint jump;
        jump = longint'(next) - longint'(tgt);
        if (jump < 0) jump = -jump;
        if (jump > longint'(tolerance)) integ = '0;
        tgt = next;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] wheel_drive(
        input logic signed [DATA_WIDTH-1:0] tgt,
        input logic signed [DATA_WIDTH-1:0] meas,
        input logic signed [DATA_WIDTH-1:0] integ);
        longint prop;
        prop = ((longint'(tgt) - longint'(meas)) * longint'(gain_p)) >>> FRAC_BITS;
        return DATA_WIDTH'(clamp_speed(prop + longint'(integ)));
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] wheel_integrate(
        input logic signed [DATA_WIDTH-1:0] tgt,
        input logic signed [DATA_WIDTH-1:0] meas,
        input logic signed [DATA_WIDTH-1:0] integ);
        longint leak;
        longint gain_term;
        leak = (longint'(integ) * longint'(decay)) >>> DECAY_BITS;
        gain_term = ((longint'(tgt) - longint'(meas)) * longint'(gain_i)) >>> FRAC_BITS;
        return DATA_WIDTH'(clamp_speed(leak + gain_term));
    endfunction

    always @(posedge aclk) begin
        drive_cmd_t want;
        drive_cmd_t got;
        if (!aresetn) begin
            tgt_left    = '0;
            tgt_right   = '0;
            integ_left  = '0;
            integ_right = '0;
            gain_p      = int'(P_GAIN_RST);
            gain_i      = int'(I_GAIN_RST);
            decay       = int'(I_DECAY_RST);
            tolerance   = int'(TOL_RST);
            fail_total  = 0;
            drive_queue.delete();
            mismatch_count     <= 0;
            drives_outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_P_GAIN:  gain_p    = int'(cfg_wr_data);
                    CFG_I_GAIN:  gain_i    = int'(cfg_wr_data);
                    CFG_I_DECAY: decay     = int'(cfg_wr_data);
                    CFG_TOL:     tolerance = int'(cfg_wr_data[TOL_WIDTH-1:0]);
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                got.left   = m_drive_left;
                got.right  = m_drive_right;
                got.enable = m_drive_enable;
                if (drive_queue.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected drive: left %0d right %0d enable %0b",
                                 got.left, got.right, got.enable);
                end else begin
                    want = drive_queue.pop_front();
                    if (want.left !== got.left || want.right !== got.right ||
                        want.enable !== got.enable) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("mismatch: L exp %0d got %0d R exp %0d got %0d en %0b/%0b",
                                     want.left, got.left, want.right, got.right,
                                     want.enable, got.enable);
                    end
                end
            end

            if (s_valid && s_ready) begin
                case (req_t'(s_req_type))
                    REQ_SET: begin
                        retarget(tgt_left, integ_left, s_target_left);
                        retarget(tgt_right, integ_right, s_target_right);
                        want.left   = wheel_drive(tgt_left, s_measured_left, integ_left);
                        want.right  = wheel_drive(tgt_right, s_measured_right, integ_right);
                        want.enable = 1'b1;
                        drive_queue.push_back(want);
                    end
                    REQ_TICK: begin
                        integ_left  = wheel_integrate(tgt_left, s_measured_left, integ_left);
                        integ_right = wheel_integrate(tgt_right, s_measured_right,
                                                      integ_right);
                    end
                    REQ_STOP: begin
                        tgt_left    = '0;
                        tgt_right   = '0;
                        integ_left  = '0;
                        integ_right = '0;
                        want        = '0;
                        drive_queue.push_back(want);
                    end
                    default: ;
                endcase
            end

            mismatch_count     <= fail_total;
            drives_outstanding <= drive_queue.size();
        end
    end

endmodule

>>> tb/sv/dual_wheel_pi_speed_control_unit_tb.sv
// Testbench top for the two-wheel PI speed controller: clock, reset, request
// stimulus with bursty valid, patterned result stalls, config phases, verdict.
// Depends on dwpi_pkg, dual_wheel_pi_speed_control_unit and its checker.
module dual_wheel_pi_speed_control_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwpi_pkg::*;

    localparam int DW             = DATA_WIDTH_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 142;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [DW-1:0] SPD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SPD_MIN = {1'b1, {(DW-1){1'b0}}};

    logic                     aclk             = 1'b0;
    logic                     aresetn          = 1'b0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_req_type       = REQ_SET;
    logic signed [DW-1:0]     s_target_left    = '0;
    logic signed [DW-1:0]     s_target_right   = '0;
    logic signed [DW-1:0]     s_measured_left  = '0;
    logic signed [DW-1:0]     s_measured_right = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic signed [DW-1:0]     m_drive_left;
    logic signed [DW-1:0]     m_drive_right;
    logic                     m_drive_enable;
    logic                     cfg_wr_en        = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index        = CFG_P_GAIN;
    logic [GAIN_WIDTH-1:0]    cfg_wr_data      = '0;
    int                       mismatch_count;
    int                       drives_outstanding;

    int                       burst_left = 0;
    int                       tol_now    = int'(TOL_RST);
    logic signed [DW-1:0]     last_left  = '0;
    logic signed [DW-1:0]     last_right = '0;
    logic [15:0]              ready_pattern = 16'hFFFF;
    int                       pattern_age   = 0;
    int                       idle_cycles   = 0;

    dual_wheel_pi_speed_control_unit dut (.*);

    dual_wheel_pi_speed_control_unit_checker checker_i (.*);

    always #2 aclk = ~aclk;

    // result-side stall pattern, rotated and reshuffled whenever pattern_age wraps
    always @(posedge aclk) begin
        if (pattern_age == 127) begin
            pattern_age   <= 0;
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
        end else begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        m_ready <= ready_pattern[0];
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[dual_wheel_pi_speed_control_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [DW-1:0] speed_near(input logic signed [DW-1:0] center,
                                                         input int spread);
        longint v;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? SPD_MAX : SPD_MIN;
            1, 2: return DW'($urandom);
            default: begin
                v = longint'(center) + longint'($urandom_range(0, 2 * spread))
                    - longint'(spread);
                if (v > longint'(SPD_MAX)) v = longint'(SPD_MAX);
                if (v < longint'(SPD_MIN)) v = longint'(SPD_MIN);
                return DW'(v);
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] req,
                                input logic signed [DW-1:0] tl, input logic signed [DW-1:0] tr,
                                input logic signed [DW-1:0] ml, input logic signed [DW-1:0] mr);
        s_req_type       <= req;
        s_target_left    <= tl;
        s_target_right   <= tr;
        s_measured_left  <= ml;
        s_measured_right <= mr;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // quiesce before touching config; ticks leave nothing in flight to wait on
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (drives_outstanding != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] pg, input logic [15:0] ig,
                             input logic [15:0] dc, input logic [15:0] tl);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_P_GAIN;
        cfg_wr_data <= pg;
        @(posedge aclk);
        cfg_index   <= CFG_I_GAIN;
        cfg_wr_data <= ig;
        @(posedge aclk);
        cfg_index   <= CFG_I_DECAY;
        cfg_wr_data <= dc;
        @(posedge aclk);
        cfg_index   <= CFG_TOL;
        cfg_wr_data <= tl;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tol_now = int'(tl[TOL_WIDTH-1:0]);
    endtask

    task automatic random_request(output bit counted);
        int pick;
        logic [1:0] req;
        logic signed [DW-1:0] tl;
        logic signed [DW-1:0] tr;
        logic signed [DW-1:0] ml;
        logic signed [DW-1:0] mr;
        pick = $urandom_range(0, 99);
        if (pick < 40)      req = REQ_SET;
        else if (pick < 85) req = REQ_TICK;
        else if (pick < 94) req = REQ_STOP;
        else                req = REQ_UNUSED;
        tl = speed_near(last_left, tol_now + 64);
        tr = speed_near(last_right, tol_now + 64);
        if (req == REQ_SET) begin
            ml = speed_near(tl, 1500);
            mr = speed_near(tr, 1500);
        end else begin
            ml = speed_near(last_left, 1500);
            mr = speed_near(last_right, 1500);
        end
        send_request(req, tl, tr, ml, mr);
        if (req == REQ_SET) begin
            last_left  = tl;
            last_right = tr;
        end else if (req == REQ_STOP) begin
            last_left  = '0;
            last_right = '0;
        end
        counted = (req != REQ_UNUSED);
    endtask

    initial begin
        int done;
        bit counted;
        logic [15:0] pg;
        logic [15:0] ig;
        logic [15:0] dc;
        logic [15:0] tl;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // saturation, tolerance boundary, rounding, stop, unused code
        send_request(REQ_SET,  SPD_MAX, SPD_MIN, SPD_MIN, SPD_MAX);
        send_request(REQ_TICK, '0, '0, SPD_MIN, SPD_MAX);
        send_request(REQ_TICK, '0, '0, SPD_MIN, SPD_MAX);
        send_request(REQ_SET,  SPD_MAX, SPD_MIN, SPD_MAX, SPD_MIN);
        send_request(REQ_SET,  SPD_MAX - 16'sd205, SPD_MIN + 16'sd205, '0, '0);
        send_request(REQ_SET,  SPD_MAX - 16'sd411, SPD_MIN + 16'sd205, '0, '0);
        send_request(REQ_TICK, SPD_MAX, SPD_MAX, SPD_MAX, SPD_MIN);
        send_request(REQ_UNUSED, SPD_MIN, SPD_MAX, 16'h5A5A, 16'hA5A5);
        send_request(REQ_SET,  SPD_MAX - 16'sd411, SPD_MIN + 16'sd205, '0, '0);
        send_request(REQ_STOP, SPD_MAX, SPD_MIN, SPD_MAX, SPD_MIN);
        send_request(REQ_TICK, '0, '0, 16'sd1000, -16'sd1000);
        send_request(REQ_SET,  '0, '0, '0, '0);
        send_request(REQ_SET,  -16'sd1, 16'sd1, '0, '0);
        send_request(REQ_TICK, '0, '0, 16'sd1, -16'sd1);
        send_request(REQ_SET,  -16'sd1, 16'sd1, SPD_MIN, SPD_MAX);
        send_request(REQ_STOP, '0, '0, '0, '0);
        send_request(REQ_STOP, '1, '1, '1, '1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
                1: configure(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
                2: configure(P_GAIN_RST, I_GAIN_RST, I_DECAY_RST, {1'b0, TOL_RST});
                default: begin
                    pg = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8191));
                    ig = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2047));
                    dc = $urandom_range(0, 1) ? 16'($urandom)
                                              : 16'($urandom_range(55000, 65535));
                    tl = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1023));
                    configure(pg, ig, dc, tl);
                end
            endcase
            done = 0;
            while (done < PHASE_REQUESTS) begin
                random_request(counted);
                if (counted) done++;
            end
        end

        drain();
        if (mismatch_count == 0 && drives_outstanding == 0)
            $display("[dual_wheel_pi_speed_control_unit] OK");
        else
            $display("[dual_wheel_pi_speed_control_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/dwpi_pkg.sv
design/dwpi_cfg.sv
design/dwpi_wheel.sv
design/dual_wheel_pi_speed_control_unit.sv
design/dwpi_checker.sv
tb/sv/dual_wheel_pi_speed_control_unit_checker.sv
tb/sv/dual_wheel_pi_speed_control_unit_tb.sv
